// ----- rtl/cso_pkg.sv -----
// Shared types and constants for the filtered cosine similarity block.
// Used by the accumulator front end, the finish unit and the top level.
package cso_pkg;

  localparam int ValueWidth = 24;
  localparam int LimitWidth = 11;
  localparam int SimWidth = 17;
  localparam int SumWidth = 64;
  localparam int RootWidth = 32;
  localparam int DefaultFractionBits = 12;
  localparam int DefaultMaxElements = 4096;
  localparam logic [LimitWidth-1:0] LimitReset = 11'd1000;
  localparam logic [0:0] RegOutlierLimit = 1'b0;

  typedef struct packed {
    logic signed [SumWidth-1:0] dot;
    logic [SumWidth-1:0] psq;
    logic [SumWidth-1:0] gsq;
  } sums_t;

  typedef enum logic [2:0] {
    FinIdle,
    FinRoot,
    FinMul,
    FinDiv,
    FinOut
  } fin_state_t;

endpackage

// ----- rtl/cso_accum.sv -----
// Front end: classifies element pairs and accumulates the three saturating sums.
// Depends on cso_pkg. Hands finished sums to a two-entry queue on the last pair.
module cso_accum #(
  parameter int FractionBits = cso_pkg::DefaultFractionBits
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [cso_pkg::ValueWidth-1:0] probe_value,
  input  logic signed [cso_pkg::ValueWidth-1:0] gallery_value,
  input  logic probe_nan,
  input  logic gallery_nan,
  input  logic last,
  input  logic [cso_pkg::LimitWidth-1:0] limit,
  output logic q_valid,
  input  logic q_ready,
  output cso_pkg::sums_t q_sums
);
  localparam int MagWidth = cso_pkg::ValueWidth;
  localparam int BoundWidth = cso_pkg::LimitWidth + FractionBits;
  localparam int CmpWidth = BoundWidth + MagWidth;
  localparam int PW = 2 * MagWidth;

  cso_pkg::sums_t acc;
  cso_pkg::sums_t fifo [2];
  logic wp, rp;
  logic [1:0] count;
  logic [MagWidth-1:0] pm, gm;
  logic [BoundWidth-1:0] bound;
  logic p_ok, g_ok, sgn;
  logic [PW-1:0] pg, pp, gg;
  logic [cso_pkg::SumWidth-1:0] dot_u, room, psum, gsum;
  logic [cso_pkg::SumWidth:0] pwide, gwide;
  cso_pkg::sums_t acc_next;
  logic push, pop;

  assign pm = probe_value[MagWidth-1] ? MagWidth'(-probe_value) : probe_value;
  assign gm = gallery_value[MagWidth-1] ? MagWidth'(-gallery_value) : gallery_value;
  assign bound = {limit, FractionBits'(0)};
  assign p_ok = !probe_nan && (CmpWidth'(pm) <= CmpWidth'(bound));
  assign g_ok = !gallery_nan && (CmpWidth'(gm) <= CmpWidth'(bound));
  assign sgn = probe_value[MagWidth-1] ^ gallery_value[MagWidth-1];
  assign pg = pm * gm;
  assign pp = pm * pm;
  assign gg = gm * gm;

  always_comb begin
    acc_next = acc;
    dot_u = acc.dot;
    if (p_ok && g_ok) begin
      if (sgn) begin
        room = dot_u - {1'b1, 63'd0};
        if (cso_pkg::SumWidth'(pg) >= room) acc_next.dot = {1'b1, 63'd0};
        else acc_next.dot = dot_u - cso_pkg::SumWidth'(pg);
      end else begin
        room = {1'b0, {63{1'b1}}} - dot_u;
        if (cso_pkg::SumWidth'(pg) >= room) acc_next.dot = {1'b0, {63{1'b1}}};
        else acc_next.dot = dot_u + cso_pkg::SumWidth'(pg);
      end
    end else begin
      room = '0;
    end
    pwide = {1'b0, acc.psq} + (cso_pkg::SumWidth+1)'(pp);
    gwide = {1'b0, acc.gsq} + (cso_pkg::SumWidth+1)'(gg);
    psum = pwide[cso_pkg::SumWidth] ? '1 : pwide[cso_pkg::SumWidth-1:0];
    gsum = gwide[cso_pkg::SumWidth] ? '1 : gwide[cso_pkg::SumWidth-1:0];
    if (p_ok) acc_next.psq = psum;
    if (g_ok) acc_next.gsq = gsum;
  end

  assign in_ready = count != 2'd2;
  assign push = in_valid && in_ready && last;
  assign pop = q_valid && q_ready;
  assign q_valid = count != 2'd0;
  assign q_sums = fifo[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) acc <= last ? '0 : acc_next;
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= acc_next;
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) push |=> q_valid)
    else $error("pushed sums not visible");
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready && last) |=> acc == '0)
    else $error("sums not cleared after last");
endmodule

// ----- rtl/cso_finish.sv -----
// Back end: iterative square roots, norm product and 15-bit quotient.
// Depends on cso_pkg. Takes sums from the queue, holds the result in an output register.
module cso_finish (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cso_pkg::sums_t q_sums,
  output logic out_valid,
  input  logic out_ready,
  output logic [cso_pkg::SimWidth-1:0] out_sim,
  output logic out_zero
);
  localparam int SW = cso_pkg::SumWidth;
  localparam int RW = cso_pkg::RootWidth;

  cso_pkg::fin_state_t state, state_next;
  logic [SW-1:0] prem, proot, pbit, grem, groot, gbit;
  logic [SW-1:0] mag, den, r;
  logic [15:0] q;
  logic [3:0] step;
  logic neg;
  logic [SW-1:0] ps, gs;
  logic [SW:0] r2;
  logic ld, rs, dv;

  assign ps = proot + pbit;
  assign gs = groot + gbit;
  assign r2 = {r, 1'b0};
  assign q_ready = state == cso_pkg::FinIdle;

  always_comb begin
    state_next = state;
    ld = 1'b0; rs = 1'b0; dv = 1'b0;
    unique case (state)
      cso_pkg::FinIdle: if (q_valid) begin state_next = cso_pkg::FinRoot; ld = 1'b1; end
      cso_pkg::FinRoot: begin
        rs = 1'b1;
        if (pbit[SW-1:2] == '0 && gbit[SW-1:2] == '0) state_next = cso_pkg::FinMul;
      end
      cso_pkg::FinMul: state_next = cso_pkg::FinDiv;
      cso_pkg::FinDiv: begin
        dv = 1'b1;
        if (den == '0 || mag >= den || step == 4'd14) state_next = cso_pkg::FinOut;
      end
      cso_pkg::FinOut: if (!out_valid || out_ready) state_next = cso_pkg::FinIdle;
      default: state_next = cso_pkg::FinIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cso_pkg::FinIdle;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == cso_pkg::FinOut && (!out_valid || out_ready)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      prem <= q_sums.psq; grem <= q_sums.gsq;
      proot <= '0; groot <= '0;
      pbit <= {2'b01, 62'd0}; gbit <= {2'b01, 62'd0};
      neg <= q_sums.dot[SW-1];
      mag <= q_sums.dot[SW-1] ? SW'(-q_sums.dot) : SW'(q_sums.dot);
    end
    if (rs) begin
      if (pbit != '0) begin
        if (pbit > prem && proot == '0) begin
        end else if (prem >= ps) begin
          prem <= prem - ps; proot <= (proot >> 1) + pbit;
        end else proot <= proot >> 1;
        pbit <= pbit >> 2;
      end
      if (gbit != '0) begin
        if (gbit > grem && groot == '0) begin
        end else if (grem >= gs) begin
          grem <= grem - gs; groot <= (groot >> 1) + gbit;
        end else groot <= groot >> 1;
        gbit <= gbit >> 2;
      end
    end
    if (state == cso_pkg::FinMul) begin
      den <= RW'(proot) * RW'(groot);
      r <= mag; q <= '0; step <= '0;
    end
    if (dv) begin
      step <= step + 4'd1;
      if (den != '0 && mag < den) begin
        if (r2[SW] || r2[SW-1:0] >= den) begin
          r <= r2[SW-1:0] - den; q <= {q[14:0], 1'b1};
        end else begin
          r <= r2[SW-1:0]; q <= {q[14:0], 1'b0};
        end
      end
    end
    if (state == cso_pkg::FinOut && (!out_valid || out_ready)) begin
      out_zero <= den == '0;
      if (den == '0) out_sim <= '0;
      else if (mag >= den) out_sim <= neg ? -17'sd32768 : 17'd32768;
      else out_sim <= neg ? -{1'b0, q} : {1'b0, q};
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_valid && q_ready |=> state == cso_pkg::FinRoot)
    else $error("load did not start");
  assert property (@(posedge clk) disable iff (rst) state == cso_pkg::FinDiv |-> step <= 4'd14)
    else $error("divide overrun");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result lost");
endmodule

// ----- rtl/cosine_similarity_outlier_filtered.sv -----
// Filtered cosine similarity. Accepts one element pair per cycle while the queue has room; a last
// pair's sums are queued and then pass through the back end (32-step dual square root, multiply,
// up to 15-step divide, one divide step when a norm is zero or the ratio saturates) to the output.
// The back end holds one vector at a time; a two-entry queue lets accumulation go on,
// and input stalls only while both entries wait. Synchronous active-high reset clears sums,
// queue and outlier_limit to 1000. Depends on cso_pkg, cso_accum and cso_finish.
module cosine_similarity_outlier_filtered #(
  parameter int FractionBits = cso_pkg::DefaultFractionBits
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [47:0] s_tdata,  // probe_value, gallery_value
  input  logic [1:0] s_tuser,   // probe_not_number, gallery_not_number
  input  logic s_tlast,         // last_element
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata,  // similarity, zero fill
  output logic m_tuser,         // norms_zero
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [cso_pkg::LimitWidth-1:0] limit;
  logic qv, qr;
  cso_pkg::sums_t qs;
  logic [cso_pkg::SimWidth-1:0] sim;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cso_pkg::RegOutlierLimit) ? 32'(limit) : '0;
  assign m_tdata = {7'b0, sim};

  always_ff @(posedge clk) begin
    if (rst) limit <= cso_pkg::LimitReset;
    else if (psel && penable && pwrite && paddr[2] == cso_pkg::RegOutlierLimit)
      limit <= pwdata[cso_pkg::LimitWidth-1:0];
  end

  cso_accum #(.FractionBits(FractionBits)) u_accum (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .probe_value(s_tdata[23:0]), .gallery_value(s_tdata[47:24]),
    .probe_nan(s_tuser[0]), .gallery_nan(s_tuser[1]), .last(s_tlast),
    .limit, .q_valid(qv), .q_ready(qr), .q_sums(qs)
  );

  cso_finish u_finish (
    .clk, .rst, .q_valid(qv), .q_ready(qr), .q_sums(qs),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_sim(sim), .out_zero(m_tuser)
  );
endmodule
